@@ src/irs_pkg.sv @@
// Package for the indexed random set: sizes, mode, status and unit op codes.
// No dependencies; imported by irs_unit, indexed_random_set and the testbench.
package irs_pkg;

    localparam int MAX_ENTRIES  = 256;
    localparam int INDEX_SPACE  = 256;
    localparam int IDX_W        = 8;
    localparam int COUNT_W      = 9;
    localparam int DRAW_W       = 16;
    localparam int STATUS_W     = 3;
    localparam logic [COUNT_W-1:0] SIZE_RESET = COUNT_W'(256);

    typedef enum logic [1:0] {
        MODE_ENQ   = 2'd0,
        MODE_DEL   = 2'd1,
        MODE_DEQ   = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_RANGE       = 3'd1,
        ST_PRESENT     = 3'd2,
        ST_NOT_PRESENT = 3'd3,
        ST_EMPTY       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        UNIT_INC   = 2'd0,
        UNIT_DEC   = 2'd1,
        UNIT_SCALE = 2'd2
    } unit_op_t;

endpackage

@@ src/irs_ram.sv @@
// Generic RAM: one write port, two registered read ports.
// Depends on nothing.
module irs_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ src/irs_unit.sv @@
// Shared arithmetic unit: count increment, decrement and slot scaling.
// Depends on irs_pkg.
module irs_unit
    import irs_pkg::*;
(
    input  unit_op_t             op,
    input  logic [COUNT_W-1:0]   count_in,
    input  logic [DRAW_W-1:0]    draw_in,
    output logic [COUNT_W-1:0]   result
);

    logic [COUNT_W+DRAW_W-1:0] product;

    assign product = (COUNT_W+DRAW_W)'(count_in) * (COUNT_W+DRAW_W)'(draw_in);

    always_comb
    begin
        unique case (op)
            UNIT_INC:   result = count_in + COUNT_W'(1);
            UNIT_DEC:   result = count_in - COUNT_W'(1);
            UNIT_SCALE: result = product[COUNT_W+DRAW_W-1:DRAW_W];
            default:    result = count_in;
        endcase
    end

endmodule

@@ src/indexed_random_set.sv @@
// Indexed random set top level: sequencer, member flags, slot and map RAMs.
// Depends on irs_pkg, irs_ram and irs_unit.
//
// An item is taken when start is high and busy is low; its result appears on
// the result ports for one cycle with done high, and the receiver cannot hold
// it off. Enqueue, query and every error finish at once: done rises in the
// cycle after the item is taken and busy stays low. Delete and dequeue of a
// present member hold busy through S_PICK (map or scale), S_FETCH (slot
// reads) and S_MOVE (slot move), as set by the registered reads of the slot
// RAM and the move of the last slot into the hole. The user writes active_size
// (cfg_write/cfg_data) only while no item is in work; the block doesn't check.
module indexed_random_set
    import irs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [COUNT_W-1:0]   cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           mode,
    input  logic [IDX_W-1:0]     item_index,
    input  logic [DRAW_W-1:0]    random_draw,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [IDX_W-1:0]     chosen_index,
    output logic                 is_member,
    output logic [COUNT_W-1:0]   entry_count,
    output logic                 is_empty
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_FETCH,
        S_MOVE
    } state_t;

    state_t                 state_reg;
    mode_t                  mode_reg;
    logic [DRAW_W-1:0]      draw_reg;
    logic [IDX_W-1:0]       pos_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     size_reg;
    logic [INDEX_SPACE-1:0] flag_reg;
    logic                   done_reg;
    status_t                status_reg;
    logic [IDX_W-1:0]       chosen_reg;
    logic                   member_reg;

    mode_t              in_mode;
    logic               accept;
    logic               in_range;
    logic               was_in;
    unit_op_t           unit_op;
    logic [COUNT_W-1:0] unit_res;

    logic               slot_wr_en;
    logic [IDX_W-1:0]   slot_wr_addr;
    logic [IDX_W-1:0]   slot_wr_data;
    logic [IDX_W-1:0]   slot_rd_a;
    logic [IDX_W-1:0]   slot_rd_b;
    logic               map_wr_en;
    logic [IDX_W-1:0]   map_wr_addr;
    logic [IDX_W-1:0]   map_wr_data;
    logic [IDX_W-1:0]   map_rd;

    assign in_mode  = mode_t'(mode);
    assign accept   = start && (state_reg == S_IDLE);
    assign in_range = {1'b0, item_index} < size_reg;
    assign was_in   = flag_reg[item_index];

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  unit_op = UNIT_INC;
            S_PICK:  unit_op = UNIT_SCALE;
            S_FETCH: unit_op = UNIT_DEC;
            S_MOVE:  unit_op = UNIT_DEC;
            default: unit_op = UNIT_DEC;
        endcase
    end

    irs_unit u_unit (
        .op       (unit_op),
        .count_in (count_reg),
        .draw_in  (draw_reg),
        .result   (unit_res)
    );

    // enqueue writes at accept; the move writes in S_MOVE
    always_comb
    begin
        slot_wr_en   = 1'b0;
        slot_wr_addr = count_reg[IDX_W-1:0];
        slot_wr_data = item_index;
        map_wr_en    = 1'b0;
        map_wr_addr  = item_index;
        map_wr_data  = count_reg[IDX_W-1:0];
        if (state_reg == S_MOVE)
        begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = pos_reg;
            slot_wr_data = slot_rd_b;
            map_wr_en    = 1'b1;
            map_wr_addr  = slot_rd_b;
            map_wr_data  = pos_reg;
        end
        else if (accept && in_mode == MODE_ENQ && in_range && !was_in)
        begin
            slot_wr_en = 1'b1;
            map_wr_en  = 1'b1;
        end
    end

    irs_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(IDX_W)) u_slot_ram (
        .clk       (clk),
        .wr_en     (slot_wr_en),
        .wr_addr   (slot_wr_addr),
        .wr_data   (slot_wr_data),
        .rd_addr_a (pos_reg),
        .rd_addr_b (unit_res[IDX_W-1:0]),
        .rd_data_a (slot_rd_a),
        .rd_data_b (slot_rd_b)
    );

    irs_ram #(.DEPTH(INDEX_SPACE), .WIDTH(IDX_W)) u_map_ram (
        .clk       (clk),
        .wr_en     (map_wr_en),
        .wr_addr   (map_wr_addr),
        .wr_data   (map_wr_data),
        .rd_addr_a (item_index),
        .rd_addr_b (item_index),
        .rd_data_a (map_rd),
        .rd_data_b ()
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            size_reg   <= SIZE_RESET;
            count_reg  <= '0;
            flag_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            chosen_reg <= '0;
            member_reg <= 1'b0;
            mode_reg   <= MODE_ENQ;
            draw_reg   <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                size_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg   <= in_mode;
                        draw_reg   <= random_draw;
                        member_reg <= (in_mode == MODE_DEQ) ? 1'b0 : was_in;
                        chosen_reg <= '0;
                        unique case (in_mode)
                            MODE_ENQ:
                            begin
                                done_reg <= 1'b1;
                                if (!in_range)
                                begin
                                    status_reg <= ST_RANGE;
                                end
                                else if (was_in)
                                begin
                                    status_reg <= ST_PRESENT;
                                end
                                else
                                begin
                                    status_reg           <= ST_OK;
                                    flag_reg[item_index] <= 1'b1;
                                    count_reg            <= unit_res;
                                end
                            end
                            MODE_DEL:
                            begin
                                if (!in_range)
                                begin
                                    status_reg <= ST_RANGE;
                                    done_reg   <= 1'b1;
                                end
                                else if (!was_in || count_reg == '0)
                                begin
                                    status_reg <= ST_NOT_PRESENT;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_PICK;
                                end
                            end
                            MODE_DEQ:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_PICK;
                                end
                            end
                            MODE_QUERY:
                            begin
                                status_reg <= in_range ? ST_OK : ST_RANGE;
                                done_reg   <= 1'b1;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_PICK:
                begin
                    pos_reg   <= (mode_reg == MODE_DEQ) ? unit_res[IDX_W-1:0] : map_rd;
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    state_reg <= S_MOVE;
                end
                S_MOVE:
                begin
                    flag_reg[slot_rd_a] <= 1'b0;
                    count_reg           <= unit_res;
                    status_reg          <= ST_OK;
                    chosen_reg          <= (mode_reg == MODE_DEQ) ? slot_rd_a : '0;
                    done_reg            <= 1'b1;
                    state_reg           <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign chosen_index = chosen_reg;
    assign is_member    = member_reg;
    assign entry_count  = count_reg;
    assign is_empty     = (count_reg == '0);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_ENTRIES))
        else $error("member count above capacity");

    a_item_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("item taken without result or work");

    a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) |-> (count_reg != '0))
        else $error("slot move with empty set");

    a_deq_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_reg == MODE_DEQ && status_reg == ST_OK && $past(state_reg) == S_MOVE)
            |-> !flag_reg[chosen_reg])
        else $error("dequeued index still flagged");

endmodule

@@ verif/indexed_random_set_tb.sv @@
// Testbench for indexed_random_set: directed table, then random request phases
// over several active_size settings; results checked against table or model.
// Depends on irs_pkg and the indexed_random_set RTL.
module indexed_random_set_tb;
    import irs_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        status_t              st;
        logic [IDX_W-1:0]     chosen;
        logic                 was_member;
        logic [COUNT_W-1:0]   count;
        logic                 empty;
    } set_result_t;

    typedef enum bit {ROW_REQ, ROW_SIZE} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        mode_t                m;
        logic [IDX_W-1:0]     idx;
        logic [DRAW_W-1:0]    draw;
        logic [COUNT_W-1:0]   size;
        bit                   typed;
        set_result_t          want;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [COUNT_W-1:0]   cfg_data;
    logic                 start;
    logic                 busy;
    mode_t                mode;
    logic [IDX_W-1:0]     item_index;
    logic [DRAW_W-1:0]    random_draw;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [IDX_W-1:0]     chosen_index;
    logic                 is_member;
    logic [COUNT_W-1:0]   entry_count;
    logic                 is_empty;

    // model of the set
    logic [IDX_W-1:0]     slot_member [MAX_ENTRIES];
    logic [IDX_W-1:0]     member_slot [INDEX_SPACE];
    logic                 in_set      [INDEX_SPACE];
    int unsigned          set_count;
    logic [COUNT_W-1:0]   size_limit;

    set_result_t          awaited_results [$];
    plan_row_t            plan [$];
    int                   mismatch_count;
    int                   burst_left;

    indexed_random_set DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .item_index   (item_index),
        .random_draw  (random_draw),
        .done         (done),
        .status       (status),
        .chosen_index (chosen_index),
        .is_member    (is_member),
        .entry_count  (entry_count),
        .is_empty     (is_empty)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void drop_slot(input int unsigned pos);
        logic [IDX_W-1:0] gone;
        logic [IDX_W-1:0] last;
        gone = slot_member[pos];
        set_count--;
        last = slot_member[set_count];
        slot_member[pos] = last;
        member_slot[last] = IDX_W'(pos);
        in_set[gone] = 1'b0;
    endfunction

    function automatic set_result_t apply_request(input mode_t m, input logic [IDX_W-1:0] idx,
                                                  input logic [DRAW_W-1:0] draw);
        set_result_t r;
        logic was;
        logic ok_range;
        int unsigned pos;
        was = in_set[idx];
        ok_range = ({1'b0, idx} < size_limit);
        r.st = ST_OK;
        r.chosen = '0;
        r.was_member = was;
        case (m)
            MODE_ENQ:
            begin
                if (!ok_range)
                    r.st = ST_RANGE;
                else if (was || set_count >= MAX_ENTRIES)
                    r.st = ST_PRESENT;
                else
                begin
                    member_slot[idx] = IDX_W'(set_count);
                    slot_member[set_count] = idx;
                    in_set[idx] = 1'b1;
                    set_count++;
                end
            end
            MODE_DEL:
            begin
                if (!ok_range)
                    r.st = ST_RANGE;
                else if (!was || set_count == 0 || member_slot[idx] >= set_count)
                    r.st = ST_NOT_PRESENT;
                else
                    drop_slot(member_slot[idx]);
            end
            MODE_DEQ:
            begin
                r.was_member = 1'b0;
                if (set_count == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    pos = (set_count * draw) >> 16;
                    r.chosen = slot_member[pos];
                    drop_slot(pos);
                end
            end
            default:
                r.st = ok_range ? ST_OK : ST_RANGE;
        endcase
        r.count = COUNT_W'(set_count);
        r.empty = (set_count == 0);
        return r;
    endfunction

    function automatic int eff_size();
        return (size_limit > MAX_ENTRIES) ? MAX_ENTRIES : int'(size_limit);
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int eff;
        eff = eff_size();
        if (eff == 0)
            return IDX_W'($urandom_range(0, 255));
        return IDX_W'($urandom_range(0, eff - 1));
    endfunction

    function automatic logic [IDX_W-1:0] free_index();
        int eff;
        int s;
        int k;
        eff = eff_size();
        if (eff == 0)
            return IDX_W'($urandom_range(0, 255));
        s = $urandom_range(0, eff - 1);
        for (k = 0; k < eff; k++)
            if (!in_set[(s + k) % eff])
                return IDX_W'((s + k) % eff);
        return IDX_W'(s);
    endfunction

    function automatic logic [DRAW_W-1:0] pick_draw();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return DRAW_W'($urandom_range(0, 65535));
    endfunction

    // mostly short gaps, a few long ones, and bursts with none
    function automatic int next_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic plan_row_t rq(input mode_t m, input int idx, input int draw,
                                     input bit typed = 1'b0, input status_t st = ST_OK,
                                     input int ch = 0, input int mem = 0, input int cnt = 0,
                                     input int emp = 0);
        plan_row_t p;
        p.kind = ROW_REQ;
        p.m = m;
        p.idx = IDX_W'(idx);
        p.draw = DRAW_W'(draw);
        p.size = '0;
        p.typed = typed;
        p.want.st = st;
        p.want.chosen = IDX_W'(ch);
        p.want.was_member = mem[0];
        p.want.count = COUNT_W'(cnt);
        p.want.empty = emp[0];
        return p;
    endfunction

    function automatic plan_row_t sz(input int v);
        plan_row_t p;
        p = rq(MODE_QUERY, 0, 0);
        p.kind = ROW_SIZE;
        p.size = COUNT_W'(v);
        return p;
    endfunction

    // Called at the edge that took the previous item, or with start low.
    task automatic send_item(input mode_t m, input logic [IDX_W-1:0] idx,
                             input logic [DRAW_W-1:0] draw, input int gap,
                             input bit typed = 1'b0, input set_result_t want = '0);
        set_result_t r;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        mode        <= m;
        item_index  <= idx;
        random_draw <= draw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = apply_request(m, idx, draw);
        awaited_results.push_back(typed ? want : r);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input logic [COUNT_W-1:0] v);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        size_limit = v;
    endtask

    task automatic run_phase(input int n_req, input bit fill_up);
        int i;
        int r;
        int r2;
        mode_t m;
        logic [IDX_W-1:0] idx;
        // fill to the size limit with fresh indices, some queries mixed in
        if (fill_up)
            while (set_count < eff_size())
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(MODE_QUERY, IDX_W'($urandom_range(0, 255)), pick_draw(), next_gap());
                else
                    send_item(MODE_ENQ, free_index(), pick_draw(), next_gap());
            end
        for (i = 0; i < n_req; i++)
        begin
            r = $urandom_range(0, 99);
            r2 = $urandom_range(0, 99);
            if (i < n_req / 2)
                m = (r < 60) ? MODE_ENQ : (r < 75) ? MODE_DEL : (r < 90) ? MODE_DEQ : MODE_QUERY;
            else
                m = (r < 15) ? MODE_ENQ : (r < 50) ? MODE_DEL : (r < 85) ? MODE_DEQ : MODE_QUERY;
            if (m == MODE_ENQ && r2 < 50)
                idx = free_index();
            else if (m == MODE_DEL && r2 < 60 && set_count > 0)
                idx = slot_member[$urandom_range(0, set_count - 1)];
            else if (r2 < 85)
                idx = pick_index();
            else
                idx = IDX_W'($urandom_range(0, 255));
            send_item(m, idx, pick_draw(), next_gap());
        end
    endtask

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        set_result_t want;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual status %0d count %0d",
                         $time, status, entry_count);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("status", COUNT_W'(want.st), COUNT_W'(status));
                check_field("chosen_index", COUNT_W'(want.chosen), COUNT_W'(chosen_index));
                check_field("is_member", COUNT_W'(want.was_member), COUNT_W'(is_member));
                check_field("entry_count", want.count, entry_count);
                check_field("is_empty", COUNT_W'(want.empty), COUNT_W'(is_empty));
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_data    = '0;
        start       = 1'b0;
        mode        = MODE_ENQ;
        item_index  = '0;
        random_draw = '0;
        mismatch_count = 0;
        burst_left  = 0;
        set_count   = 0;
        size_limit  = SIZE_RESET;
        for (int k = 0; k < INDEX_SPACE; k++)
            in_set[k] = 1'b0;

        plan.push_back(rq(MODE_DEQ,   0,   16'h0000, 1, ST_EMPTY,       0,   0, 0, 1));
        plan.push_back(rq(MODE_DEL,   5,   16'h0000, 1, ST_NOT_PRESENT, 0,   0, 0, 1));
        plan.push_back(rq(MODE_QUERY, 255, 16'hFFFF, 1, ST_OK,          0,   0, 0, 1));
        plan.push_back(rq(MODE_ENQ,   0,   16'h0000, 1, ST_OK,          0,   0, 1, 0));
        plan.push_back(rq(MODE_ENQ,   255, 16'hFFFF, 1, ST_OK,          0,   0, 2, 0));
        plan.push_back(rq(MODE_ENQ,   0,   16'h0000, 1, ST_PRESENT,     0,   1, 2, 0));
        plan.push_back(rq(MODE_QUERY, 0,   16'h0000, 1, ST_OK,          0,   1, 2, 0));
        plan.push_back(rq(MODE_ENQ,   77,  16'h1234, 1, ST_OK,          0,   0, 3, 0));
        plan.push_back(rq(MODE_DEQ,   255, 16'h0000, 1, ST_OK,          0,   0, 2, 0));
        plan.push_back(rq(MODE_DEQ,   0,   16'hFFFF, 1, ST_OK,          255, 0, 1, 0));
        plan.push_back(rq(MODE_DEL,   77,  16'h0000, 1, ST_OK,          0,   1, 0, 1));
        plan.push_back(sz(16));
        plan.push_back(rq(MODE_ENQ,   16,  16'h0000, 1, ST_RANGE,       0,   0, 0, 1));
        plan.push_back(rq(MODE_ENQ,   15,  16'h0000, 1, ST_OK,          0,   0, 1, 0));
        plan.push_back(rq(MODE_DEL,   200, 16'h0000, 1, ST_RANGE,       0,   0, 1, 0));
        plan.push_back(rq(MODE_QUERY, 16,  16'h0000, 1, ST_RANGE,       0,   0, 1, 0));
        // members above a lowered size stay in the set
        plan.push_back(sz(256));
        plan.push_back(rq(MODE_ENQ,   100, 16'h0000, 1, ST_OK,          0,   0, 2, 0));
        plan.push_back(sz(50));
        plan.push_back(rq(MODE_DEL,   100, 16'h0000, 1, ST_RANGE,       0,   1, 2, 0));
        plan.push_back(rq(MODE_QUERY, 100, 16'h0000, 1, ST_RANGE,       0,   1, 2, 0));
        plan.push_back(rq(MODE_DEQ,   0,   16'h8000, 1, ST_OK,          100, 0, 1, 0));
        plan.push_back(sz(0));
        plan.push_back(rq(MODE_ENQ,   0,   16'h0000, 1, ST_RANGE,       0,   0, 1, 0));
        plan.push_back(rq(MODE_QUERY, 15,  16'h0000, 1, ST_RANGE,       0,   1, 1, 0));
        plan.push_back(sz(1));
        plan.push_back(rq(MODE_ENQ,   0,   16'h0000, 1, ST_OK,          0,   0, 2, 0));
        plan.push_back(rq(MODE_DEQ,   0,   16'h5A5A));
        plan.push_back(rq(MODE_DEQ,   0,   16'hFFFF));
        plan.push_back(rq(MODE_DEQ,   0,   16'h0000, 1, ST_EMPTY,       0,   0, 0, 1));
        plan.push_back(sz(511));
        plan.push_back(rq(MODE_ENQ,   255, 16'h0000, 1, ST_OK,          0,   0, 1, 0));
        plan.push_back(rq(MODE_DEL,   255, 16'h0000, 1, ST_OK,          0,   1, 0, 1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SIZE)
                set_size(plan[i].size);
            else
                send_item(plan[i].m, plan[i].idx, plan[i].draw, next_gap(),
                          plan[i].typed, plan[i].want);
        end

        set_size(256);
        run_phase(200, 1'b1);
        set_size(1);
        run_phase(195, 1'b0);
        set_size(17);
        run_phase(195, 1'b0);
        set_size(200);
        run_phase(195, 1'b0);
        set_size(0);
        run_phase(195, 1'b0);
        set_size(511);
        run_phase(195, 1'b0);
        set_size(64);
        run_phase(195, 1'b0);
        set_size(256);
        run_phase(195, 1'b0);

        wait_idle();
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
